// ===== design/sfmr_pkg.sv =====
// Shared types and constants for the streaming first-match replace block.
// Used by sfmr_step and stream_first_match_replace_top; no dependencies.
`timescale 1ns / 1ps

package sfmr_pkg;

    // Fixed sizes of the search window and of one result bundle
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int WINDOW_DEPTH    = 8;
    localparam int MAX_RESULTS     = 8;

    // Configuration register indexes
    localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // Outcome of one input byte: the bytes to emit and the next window state
    typedef struct packed {
        logic [63:0] emit_bytes;     // byte 0 leaves first
        logic [3:0]  emit_count;     // 0..8 results
        logic        emit_present;   // 0 only for a bare end marker
        logic        emit_last;      // final bundle of the file
        logic        emit_match;     // replacement made in this file
        logic [63:0] next_window;
        logic [2:0]  next_fill;
        logic        next_replaced;
    } step_t;

endpackage

// ===== design/sfmr_step.sv =====
// Combinational step of the first-match replace: window update, pattern
// compare and assembly of the result bundle for one byte. Uses sfmr_pkg.
`timescale 1ns / 1ps

module sfmr_step
    import sfmr_pkg::*;
(
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    input  logic [2:0]  fill,
    input  logic [63:0] window,
    input  logic        replaced,
    input  logic [63:0] pattern_bytes,
    input  logic [3:0]  pattern_length,
    input  logic [63:0] replacement_bytes,
    input  logic [3:0]  replacement_length,
    output step_t       step
);

    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [3:0]  seq_len;
    logic [63:0] seq;
    logic        has_full;
    logic [2:0]  drain;
    logic [63:0] aligned;
    logic [7:0]  lane_ok;
    logic        hit;
    logic        take;
    logic [3:0]  keep;
    logic [3:0]  count;
    logic [63:0] kept;
    logic [63:0] rep_shifted;
    logic [63:0] window_next;
    logic [2:0]  fill_next;
    logic        replaced_next;

    // Effective lengths after clamping
    always_comb
    begin
        if (pattern_length == 4'd0)
            plen = 4'd1;
        else if (pattern_length > 4'(MAX_PATTERN))
            plen = 4'(MAX_PATTERN);
        else
            plen = pattern_length;

        if (replacement_length > 4'(MAX_REPLACEMENT))
            rlen = 4'(MAX_REPLACEMENT);
        else
            rlen = replacement_length;
    end

    // Window with the new byte appended after the held bytes
    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            seq[8*i +: 8] = (3'(i) == fill) ? data_byte : window[8*i +: 8];
        end
    end

    assign seq_len  = {1'b0, fill} + 4'd1;
    assign has_full = !replaced && (seq_len >= plen);
    // Surplus bytes ahead of the compare position (pattern shortened mid-file)
    assign drain    = 3'(seq_len - plen);
    assign aligned  = seq >> {drain, 3'b000};

    // Per-lane compare, lanes beyond the pattern length always agree
    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            lane_ok[i] = (4'(i) >= plen) ||
                         (aligned[8*i +: 8] == pattern_bytes[8*i +: 8]);
        end
    end

    assign hit  = &lane_ok;
    assign take = has_full && hit &&
                  (({2'b00, drain} + {1'b0, rlen}) <= 5'(MAX_RESULTS));

    // Choose how many window bytes leave and what stays behind
    always_comb
    begin
        window_next   = seq;
        fill_next     = fill;
        replaced_next = replaced;
        keep          = 4'd0;

        if (replaced)
        begin
            keep          = 4'd1;
            window_next   = window;
            fill_next     = 3'd0;
            replaced_next = 1'b1;
        end
        else if (take)
        begin
            keep          = {1'b0, drain};
            fill_next     = 3'd0;
            replaced_next = 1'b1;
        end
        else if (has_full)
        begin
            keep        = end_of_file ? seq_len : ({1'b0, drain} + 4'd1);
            window_next = seq >> {({1'b0, drain} + 4'd1), 3'b000};
            fill_next   = 3'(plen - 4'd1);
        end
        else
        begin
            keep      = end_of_file ? seq_len : 4'd0;
            fill_next = seq_len[2:0];
        end

        if (end_of_file)
        begin
            fill_next     = 3'd0;
            replaced_next = 1'b0;
        end
    end

    // Leading window bytes, then the replacement shifted in behind them
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (4'(i) < keep)
                kept[8*i +: 8] = replaced ? ((i == 0) ? data_byte : 8'h00)
                                          : seq[8*i +: 8];
            else
                kept[8*i +: 8] = 8'h00;
        end
    end

    assign rep_shifted = take ? (replacement_bytes << {keep, 3'b000}) : 64'd0;
    assign count       = keep + (take ? rlen : 4'd0);

    // Bundle; an end of file with nothing to emit gives a bare marker
    always_comb
    begin
        step.next_window   = window_next;
        step.next_fill     = fill_next;
        step.next_replaced = replaced_next;
        step.emit_bytes    = kept | rep_shifted;
        step.emit_count    = count;
        step.emit_present  = 1'b1;
        step.emit_last     = end_of_file;
        step.emit_match    = end_of_file && (replaced || take);
        if (end_of_file && (count == 4'd0))
        begin
            step.emit_bytes   = 64'd0;
            step.emit_count   = 4'd1;
            step.emit_present = 1'b0;
        end
    end

endmodule

// ===== design/stream_first_match_replace_top.sv =====
// Top level of the streaming first-match replace block: input register,
// step logic (sfmr_step), result bundle register and output serialiser.
// Uses sfmr_pkg.
`timescale 1ns / 1ps

// Bytes of a file enter one per request and leave in order, with the first
// occurrence of the configured pattern (1 to 8 bytes) replaced by the
// configured replacement (0 to 8 bytes). An input request is taken every
// cycle while each byte yields at most one result and out_ready is high.
// A byte that yields n results (a match, or the window flush on
// end_of_file) holds the result register until all n are taken, one per
// cycle while out_ready is high; input is held off meanwhile. The last
// result of each file carries last_of_file and match_made; a file whose
// last byte leaves nothing gets a bare marker with byte_present low.
// Configuration writes take effect at once and belong between files.

module stream_first_match_replace_top
    import sfmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    // result stream
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_present,
    output logic        last_of_file,
    output logic        match_made
);

    logic [63:0] pattern_bytes_reg;
    logic [3:0]  pattern_length_reg;
    logic [63:0] replacement_bytes_reg;
    logic [3:0]  replacement_length_reg;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eof_reg;

    logic [63:0] window_reg;
    logic [2:0]  fill_reg;
    logic        replaced_reg;

    logic        bun_vld_reg;
    logic [63:0] bun_bytes_reg;
    logic [3:0]  bun_cnt_reg;
    logic        bun_present_reg;
    logic        bun_last_reg;
    logic        bun_match_reg;

    step_t       step;
    logic        out_fire;
    logic        bun_free;
    logic        advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= 64'd0;
            pattern_length_reg     <= 4'd1;
            replacement_bytes_reg  <= 64'd0;
            replacement_length_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data;
                REG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[3:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                REG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Handshake: the bundle frees when its last result is taken
    assign out_fire = out_valid && out_ready;
    assign bun_free = !bun_vld_reg || (out_fire && (bun_cnt_reg == 4'd1));
    assign advance  = in_vld_reg && bun_free;
    assign in_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_eof_reg  <= end_of_file;
        end
    end

    sfmr_step u_step (
        .data_byte          (in_byte_reg),
        .end_of_file        (in_eof_reg),
        .fill               (fill_reg),
        .window             (window_reg),
        .replaced           (replaced_reg),
        .pattern_bytes      (pattern_bytes_reg),
        .pattern_length     (pattern_length_reg),
        .replacement_bytes  (replacement_bytes_reg),
        .replacement_length (replacement_length_reg),
        .step               (step)
    );

    // Window state moves on as each byte passes into the bundle stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= 3'd0;
            replaced_reg <= 1'b0;
        end
        else if (advance)
        begin
            fill_reg     <= step.next_fill;
            replaced_reg <= step.next_replaced;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            window_reg <= step.next_window;
    end

    // Result bundle: loaded whole, then shifted out a byte per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bun_vld_reg <= 1'b0;
            bun_cnt_reg <= 4'd0;
        end
        else if (advance)
        begin
            bun_vld_reg <= (step.emit_count != 4'd0);
            bun_cnt_reg <= step.emit_count;
        end
        else if (out_fire)
        begin
            bun_vld_reg <= (bun_cnt_reg != 4'd1);
            bun_cnt_reg <= bun_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bun_bytes_reg   <= step.emit_bytes;
            bun_present_reg <= step.emit_present;
            bun_last_reg    <= step.emit_last;
            bun_match_reg   <= step.emit_match;
        end
        else if (out_fire)
        begin
            bun_bytes_reg <= bun_bytes_reg >> 8;
        end
    end

    // Output fields; end flags only on the final result of the bundle
    assign out_valid    = bun_vld_reg;
    assign out_byte     = bun_bytes_reg[7:0];
    assign byte_present = bun_present_reg;
    assign last_of_file = bun_last_reg && (bun_cnt_reg == 4'd1);
    assign match_made   = bun_match_reg && (bun_cnt_reg == 4'd1);

    // Checks
    a_bundle_count : assert property (@(posedge clk) disable iff (!rst_n)
        bun_vld_reg |-> (bun_cnt_reg != 4'd0))
        else $error("result bundle valid with no results");

    a_replaced_empty : assert property (@(posedge clk) disable iff (!rst_n)
        replaced_reg |-> (fill_reg == 3'd0))
        else $error("window holds bytes after replacement");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |-> bun_vld_reg)
        else $error("input held with result stage empty");

    a_bare_marker : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_present) |-> last_of_file)
        else $error("bare marker not the last result of a file");

    a_match_on_last : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && match_made) |-> last_of_file)
        else $error("match flag outside the last result");

endmodule

// ===== sim/tb_stream_first_match_replace_top.sv =====
// Self-checking testbench for stream_first_match_replace_top: a scoreboard
// class models the window and first-match replacement and checks every result.
// Depends on sfmr_pkg and the RTL under design/.
`timescale 1ns / 1ps

module tb_stream_first_match_replace_top;
    import sfmr_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 150;
    localparam int RANDOM_BYTES  = 250;
    localparam int CALM_BYTES    = 50;

    // One output byte as it should leave the block
    typedef struct packed {
        logic [7:0] value;
        logic       present;
        logic       last_flag;
        logic       matched;
    } out_byte_t;

    // Scoreboard: shadow registers, shadow window and the queue of bytes owed
    class replace_scoreboard;
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
        logic [7:0]  window [WINDOW_DEPTH];
        int          fill;
        bit          replaced;
        out_byte_t   step_out [MAX_RESULTS];
        int          step_n;
        out_byte_t   owed [$];
        int          errors;

        function new();
            pattern_bytes      = '0;
            pattern_length     = 4'd1;
            replacement_bytes  = '0;
            replacement_length = 4'd0;
            fill               = 0;
            replaced           = 1'b0;
            step_n             = 0;
            errors             = 0;
            foreach (window[i])
                window[i] = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                REG_PATTERN_BYTES:      pattern_bytes = value;
                REG_PATTERN_LENGTH:     pattern_length = value[3:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes = value;
                REG_REPLACEMENT_LENGTH: replacement_length = value[3:0];
                default: ;
            endcase
        endfunction

        function void add_out(logic [7:0] value, logic present);
            if (step_n < MAX_RESULTS)
            begin
                step_out[step_n].value     = present ? value : 8'h00;
                step_out[step_n].present   = present;
                step_out[step_n].last_flag = 1'b0;
                step_out[step_n].matched   = 1'b0;
                step_n++;
            end
        endfunction

        function logic [7:0] take_oldest();
            logic [7:0] b;
            b = window[0];
            for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                window[i] = window[i + 1];
            if (fill > 0)
                fill--;
            return b;
        endfunction

        // Works out the bytes one accepted request releases
        function void note_byte(logic [7:0] value, logic eof);
            int plen;
            int rlen;
            int drained;
            bit hit;
            step_n = 0;
            if (replaced)
                add_out(value, 1'b1);
            else
            begin
                plen = int'(pattern_length);
                if (plen < 1)
                    plen = 1;
                if (plen > MAX_PATTERN)
                    plen = MAX_PATTERN;
                rlen = int'(replacement_length);
                if (rlen > MAX_REPLACEMENT)
                    rlen = MAX_REPLACEMENT;
                drained = 0;
                window[fill] = value;
                fill++;
                // surplus left over from a longer pattern leaves first
                while (fill > plen)
                begin
                    add_out(take_oldest(), 1'b1);
                    drained++;
                end
                if (fill == plen)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < plen; i++)
                        if (window[i] != pattern_bytes[8*i +: 8])
                            hit = 1'b0;
                    if (hit && drained + rlen <= MAX_RESULTS)
                    begin
                        for (int i = 0; i < rlen; i++)
                            add_out(replacement_bytes[8*i +: 8], 1'b1);
                        fill     = 0;
                        replaced = 1'b1;
                    end
                    else
                        add_out(take_oldest(), 1'b1);
                end
            end
            // end of file: flush, mark the last byte, start afresh
            if (eof)
            begin
                while (fill > 0)
                    add_out(take_oldest(), 1'b1);
                if (step_n == 0)
                    add_out(8'h00, 1'b0);
                step_out[step_n - 1].last_flag = 1'b1;
                step_out[step_n - 1].matched   = replaced;
                fill     = 0;
                replaced = 1'b0;
            end
            for (int i = 0; i < step_n; i++)
                owed.push_back(step_out[i]);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void check_out_byte(logic [7:0] value, logic present, logic last_flag,
                                     logic matched);
            out_byte_t want;
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got byte %02h present %0b",
                         $time, value, present);
                return;
            end
            want = owed.pop_front();
            compare_field("out_byte", want.value, value);
            compare_field("byte_present", want.present, present);
            compare_field("last_of_file", want.last_flag, last_flag);
            compare_field("match_made", want.matched, matched);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_file;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        last_of_file;
    logic        match_made;

    replace_scoreboard sb;
    bit  idle_on       = 1'b1;
    bit  hold_results  = 1'b0;
    int  sent_count    = 0;
    int  quiet_cycles  = 0;
    int  cur_plen      = 1;

    stream_first_match_replace_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: too long without any request moving on either side
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: check accepted requests, stall in bursts or on a long hold
    initial
    begin : result_sink
        int stall_left;
        int hold_count;
        stall_left = 0;
        hold_count = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_out_byte(out_byte, byte_present, last_of_file, match_made);
            if (hold_results)
            begin
                out_ready <= 1'b0;
                hold_count++;
                if (hold_count >= LONG_HOLD)
                begin
                    hold_results = 1'b0;
                    hold_count   = 0;
                end
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 18);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one byte, possibly after an idle burst, and wait for acceptance
    task automatic send_byte(input logic [7:0] value, input logic eof);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= value;
        end_of_file <= eof;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        sb.note_byte(value, eof);
        sent_count++;
    endtask

    // Stop offering, let every owed byte arrive, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        if (idx == REG_PATTERN_LENGTH)
        begin
            cur_plen = int'(value[3:0]);
            if (cur_plen < 1)
                cur_plen = 1;
            if (cur_plen > MAX_PATTERN)
                cur_plen = MAX_PATTERN;
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // New random settings, extremes included, with junk above the length bits
    task automatic pick_config();
        logic [63:0] junk;
        int len;
        junk = {$urandom, $urandom};
        settle();
        case ($urandom_range(0, 5))
            0:       write_cfg(REG_PATTERN_BYTES, '0);
            1:       write_cfg(REG_PATTERN_BYTES, '1);
            default: write_cfg(REG_PATTERN_BYTES, {$urandom, $urandom});
        endcase
        if ($urandom_range(0, 7) == 0)
            len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(9, 15);
        else
            len = $urandom_range(1, 8);
        write_cfg(REG_PATTERN_LENGTH, {junk[63:4], len[3:0]});
        write_cfg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(9, 15);
        else
            len = $urandom_range(0, 8);
        write_cfg(REG_REPLACEMENT_LENGTH, {junk[3:0], junk[63:8], len[3:0]});
    endtask

    // A file built from whole patterns, partial prefixes and noise; optionally
    // the pattern length changes part way through
    task automatic send_file(input int len, input bit reshape);
        logic [7:0] file_q [$];
        int n;
        int cut;
        int part;
        while (file_q.size() < len)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    for (int k = 0; k < cur_plen; k++)
                        file_q.push_back(sb.pattern_bytes[8*k +: 8]);
                end
                1:
                begin
                    part = $urandom_range(1, cur_plen);
                    for (int k = 0; k < part; k++)
                        file_q.push_back(sb.pattern_bytes[8*k +: 8]);
                end
                2:
                begin
                    part = $urandom_range(0, cur_plen - 1);
                    file_q.push_back(sb.pattern_bytes[8*part +: 8]);
                end
                default:
                    file_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        n   = file_q.size();
        cut = (reshape && n > 1) ? $urandom_range(1, n - 1) : -1;
        for (int k = 0; k < n; k++)
        begin
            if (k == cut)
            begin
                settle();
                write_cfg(REG_PATTERN_LENGTH, 64'($urandom_range(1, 8)));
            end
            send_byte(file_q[k], k == n - 1);
        end
    endtask

    initial
    begin : stimulus
        logic [63:0] pat;
        int start;
        int files;
        bit hold_done;
        sb          = new();
        pat         = 64'h995A_4433_2211_C35A;
        hold_done   = 1'b0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_PATTERN_BYTES;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        data_byte   <= 8'h00;
        end_of_file <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: match on the last byte with nothing to put back
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        // Zero pattern length acts as one, oversized replacement acts as eight
        settle();
        write_cfg(REG_PATTERN_BYTES, 64'hAB);
        write_cfg(REG_PATTERN_LENGTH, 64'd0);
        write_cfg(REG_REPLACEMENT_BYTES, '1);
        write_cfg(REG_REPLACEMENT_LENGTH, 64'd15);
        send_byte(8'hAB, 1'b1);

        // Oversized pattern length, then shortened mid-file and matched
        settle();
        write_cfg(REG_PATTERN_BYTES, pat);
        write_cfg(REG_PATTERN_LENGTH, 64'd15);
        write_cfg(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
        write_cfg(REG_REPLACEMENT_LENGTH, 64'd2);
        for (int i = 0; i < 7; i++)
            send_byte(pat[8*i +: 8], 1'b0);
        settle();
        write_cfg(REG_PATTERN_LENGTH, 64'd2);
        send_byte(8'hC3, 1'b0);
        // a write after the match changes nothing until the file ends
        settle();
        write_cfg(REG_REPLACEMENT_LENGTH, 64'd8);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Shortened mid-file again, but surplus plus replacement overflows
        settle();
        write_cfg(REG_PATTERN_LENGTH, 64'd8);
        write_cfg(REG_REPLACEMENT_LENGTH, 64'd3);
        for (int i = 0; i < 7; i++)
            send_byte(pat[8*i +: 8], 1'b0);
        settle();
        write_cfg(REG_PATTERN_LENGTH, 64'd2);
        send_byte(8'hC3, 1'b1);

        // Random settings and files; one long hold on the result side;
        // the closing stretch runs with no idling
        start = sent_count;
        while (sent_count - start < RANDOM_BYTES)
        begin
            if (sent_count - start >= RANDOM_BYTES - CALM_BYTES)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            pick_config();
            files = $urandom_range(1, 3);
            repeat (files)
            begin
                if (!hold_done && sent_count - start >= 100)
                begin
                    hold_done    = 1'b1;
                    hold_results = 1'b1;
                    send_file(40, 1'b0);
                end
                else
                    send_file($urandom_range(1, 16), $urandom_range(0, 7) == 0);
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
